// ===== rtl/keyword_token_lexer_core_assert.svh =====
// Assertion macros shared by the lexer RTL files.
// Every macro samples on i_clk and is disabled while i_rst_n is low.
`ifndef KEYWORD_TOKEN_LEXER_CORE_ASSERT_SVH
`define KEYWORD_TOKEN_LEXER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define KWT_ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("lexer assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define KWT_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("lexer assertion failed");

`endif

// ===== rtl/kwt_pkg.sv =====
// Package for the keyword token lexer: widths, token kinds, scan modes,
// the keyword table and small helper functions. Depends on nothing.
`timescale 1ns / 1ps

package kwt_pkg;

    localparam int OFFSET_BITS   = 20;
    localparam int POSITION_BITS = 16;
    localparam int KW_MAX_LEN    = 7;
    localparam int KW_IDX_W      = $clog2(KW_MAX_LEN);
    localparam int KW_COUNT      = 12;
    localparam int KIND_W        = 6;
    localparam int OQ_DEPTH      = 4;
    localparam int OQ_PTR_W      = $clog2(OQ_DEPTH);
    localparam int OQ_CNT_W      = $clog2(OQ_DEPTH + 1);

    typedef logic [KIND_W-1:0]        t_kind;
    typedef logic [POSITION_BITS-1:0] t_pos;
    typedef logic [OFFSET_BITS-1:0]   t_off;
    typedef logic [7:0]               t_char;
    typedef t_char [KW_MAX_LEN-1:0]   t_word;

    localparam t_kind KIND_IDENT  = 6'd0;
    localparam t_kind KIND_NUMBER = 6'd1;
    localparam t_kind KIND_KW0    = 6'd2;
    localparam t_kind KIND_ASSIGN = 6'd14;
    localparam t_kind KIND_PLUS   = 6'd15;
    localparam t_kind KIND_MINUS  = 6'd16;
    localparam t_kind KIND_MUL    = 6'd17;
    localparam t_kind KIND_DIV    = 6'd18;
    localparam t_kind KIND_EQ     = 6'd19;
    localparam t_kind KIND_LSS    = 6'd20;
    localparam t_kind KIND_GTR    = 6'd21;
    localparam t_kind KIND_LEQ    = 6'd22;
    localparam t_kind KIND_GEQ    = 6'd23;
    localparam t_kind KIND_NEQ    = 6'd24;
    localparam t_kind KIND_SEMI   = 6'd25;
    localparam t_kind KIND_COLON  = 6'd26;
    localparam t_kind KIND_LPAR   = 6'd27;
    localparam t_kind KIND_RPAR   = 6'd28;
    localparam t_kind KIND_LBRK   = 6'd29;
    localparam t_kind KIND_RBRK   = 6'd30;
    localparam t_kind KIND_EOT    = 6'd31;
    localparam t_kind KIND_ERROR  = 6'd32;

    localparam t_char CH_TAB     = 8'h09;
    localparam t_char CH_NL      = 8'h0A;
    localparam t_char CH_CR      = 8'h0D;
    localparam t_char CH_SPACE   = 8'h20;
    localparam t_char CH_LPAR    = 8'h28;
    localparam t_char CH_RPAR    = 8'h29;
    localparam t_char CH_STAR    = 8'h2A;
    localparam t_char CH_PLUS    = 8'h2B;
    localparam t_char CH_MINUS   = 8'h2D;
    localparam t_char CH_SLASH   = 8'h2F;
    localparam t_char CH_0       = 8'h30;
    localparam t_char CH_9       = 8'h39;
    localparam t_char CH_COLON   = 8'h3A;
    localparam t_char CH_SEMI    = 8'h3B;
    localparam t_char CH_LT      = 8'h3C;
    localparam t_char CH_EQ      = 8'h3D;
    localparam t_char CH_GT      = 8'h3E;
    localparam t_char CH_UPPER_A = 8'h41;
    localparam t_char CH_UPPER_Z = 8'h5A;
    localparam t_char CH_LBRK    = 8'h5B;
    localparam t_char CH_RBRK    = 8'h5D;
    localparam t_char CH_LOWER_A = 8'h61;
    localparam t_char CH_LOWER_Z = 8'h7A;

    localparam t_pos POS_ONE  = POSITION_BITS'(1);
    localparam t_off OFF_ZERO = '0;
    localparam t_off OFF_ONE  = OFFSET_BITS'(1);
    localparam t_off OFF_TWO  = OFFSET_BITS'(2);

    // Keyword text is right aligned: the last character sits in the low byte.
    localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
        "program", "var", "begin", "end", "int", "if",
        "then", "else", "while", "do", "read", "write"
    };
    localparam int KW_LEN [KW_COUNT] = '{7, 3, 5, 3, 3, 2, 4, 4, 5, 2, 4, 5};

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_WORD,
        MODE_NUM,
        MODE_LT,
        MODE_GT,
        MODE_COLON,
        MODE_ERR
    } t_mode;

    typedef struct packed {
        logic        end_of_text;
        t_char       text_byte;
    } t_item;

    typedef struct packed {
        t_kind kind;
        t_pos  line;
        t_pos  column;
        t_off  offset;
        t_off  length;
        logic  last;
    } t_token;

    typedef struct packed {
        logic [1:0] n;
        t_token     tok0;
        t_token     tok1;
    } t_push;

    function automatic t_pos sat_pos(input t_pos v);
        return (&v) ? v : v + POS_ONE;
    endfunction

    function automatic t_off sat_off(input t_off v);
        return (&v) ? v : v + OFF_ONE;
    endfunction

    function automatic logic is_space(input t_char c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic logic is_letter(input t_char c);
        return ((c >= CH_UPPER_A) && (c <= CH_UPPER_Z)) ||
               ((c >= CH_LOWER_A) && (c <= CH_LOWER_Z));
    endfunction

    function automatic logic is_digit(input t_char c);
        return (c >= CH_0) && (c <= CH_9);
    endfunction

    function automatic t_kind op_kind(input t_char c);
        t_kind k;
        unique case (c)
            CH_EQ:    k = KIND_EQ;
            CH_PLUS:  k = KIND_PLUS;
            CH_MINUS: k = KIND_MINUS;
            CH_STAR:  k = KIND_MUL;
            CH_SLASH: k = KIND_DIV;
            CH_LPAR:  k = KIND_LPAR;
            CH_RPAR:  k = KIND_RPAR;
            CH_SEMI:  k = KIND_SEMI;
            CH_LBRK:  k = KIND_LBRK;
            CH_RBRK:  k = KIND_RBRK;
            default:  k = KIND_ERROR;
        endcase
        return k;
    endfunction

    // Only the characters that the current word has written are compared.
    function automatic t_kind kw_kind(input t_word w, input t_off len);
        t_kind k;
        logic  hit;
        k = KIND_IDENT;
        for (int i = 0; i < KW_COUNT; i++) begin
            hit = (len == OFFSET_BITS'(KW_LEN[i]));
            for (int j = 0; j < KW_MAX_LEN; j++) begin
                if (j < KW_LEN[i]) begin
                    hit = hit && (w[j] == KW_TEXT[i][8*(KW_LEN[i]-1-j) +: 8]);
                end
            end
            if (hit) begin
                k = KIND_KW0 + KIND_W'(i);
            end
        end
        return k;
    endfunction

endpackage

// ===== rtl/kwt_ifs.sv =====
// Handshake interfaces of the lexer: the source text channel and the
// token channel. Depends on kwt_pkg.
`timescale 1ns / 1ps

interface kwt_text_if;
    logic                 valid;
    logic                 ready;
    logic [7:0]           text_byte;
    logic                 end_of_text;

    modport source (output valid, text_byte, end_of_text, input ready);
    modport sink   (input valid, text_byte, end_of_text, output ready);
endinterface

interface kwt_token_if;
    logic                               valid;
    logic                               ready;
    logic [kwt_pkg::KIND_W-1:0]         token_kind;
    logic [kwt_pkg::POSITION_BITS-1:0]  start_line;
    logic [kwt_pkg::POSITION_BITS-1:0]  start_column;
    logic [kwt_pkg::OFFSET_BITS-1:0]    start_offset;
    logic [kwt_pkg::OFFSET_BITS-1:0]    token_length;
    logic                               last_of_run;

    modport source (output valid, token_kind, start_line, start_column, start_offset,
                    token_length, last_of_run, input ready);
    modport sink   (input valid, token_kind, start_line, start_column, start_offset,
                    token_length, last_of_run, output ready);
endinterface

// ===== rtl/kwt_scan.sv =====
// Scan stage: holds the lexer state and turns one registered item into
// zero, one or two tokens. Depends on kwt_pkg and the assertion macros.
`timescale 1ns / 1ps
`include "keyword_token_lexer_core_assert.svh"

module kwt_scan (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_fire,
    input  kwt_pkg::t_item i_item,
    output kwt_pkg::t_push o_push
);
    import kwt_pkg::*;

    t_mode r_mode, n_mode;
    t_word r_buf;
    t_off  r_wlen, n_wlen;
    t_pos  r_line, n_line, r_col, n_col, r_sline, n_sline, r_scol, n_scol;
    t_off  r_off, n_off, r_soff, n_soff;

    t_char c;
    logic  eot, busy, c_space, c_letter, c_digit, c_pend;
    logic  cont, pair_v, flush_v;
    t_kind pair_kind, flush_kind;
    t_off  flush_len;
    logic  buf_we;
    logic [KW_IDX_W-1:0] buf_idx;
    t_token p, q;
    logic  p_v, q_v;

    assign c        = i_item.text_byte;
    assign eot      = i_item.end_of_text;
    assign busy     = !eot && (r_mode != MODE_ERR);
    assign c_space  = is_space(c);
    assign c_letter = is_letter(c);
    assign c_digit  = is_digit(c);
    assign c_pend   = (c == CH_LT) || (c == CH_GT) || (c == CH_COLON);

    always_comb begin
        cont       = 1'b0;
        pair_v     = 1'b0;
        pair_kind  = KIND_ERROR;
        flush_v    = 1'b1;
        flush_kind = KIND_ERROR;
        flush_len  = OFF_ONE;
        unique case (r_mode)
            MODE_WORD: begin
                cont       = c_letter || c_digit;
                flush_kind = kw_kind(r_buf, r_wlen);
                flush_len  = r_wlen;
            end
            MODE_NUM: begin
                cont       = c_digit;
                flush_kind = KIND_NUMBER;
                flush_len  = r_wlen;
            end
            MODE_LT: begin
                pair_v     = (c == CH_EQ) || (c == CH_GT);
                pair_kind  = (c == CH_EQ) ? KIND_LEQ : KIND_NEQ;
                flush_kind = KIND_LSS;
            end
            MODE_GT: begin
                pair_v     = (c == CH_EQ);
                pair_kind  = KIND_GEQ;
                flush_kind = KIND_GTR;
            end
            MODE_COLON: begin
                pair_v     = (c == CH_EQ);
                pair_kind  = KIND_ASSIGN;
                flush_kind = KIND_COLON;
            end
            default: begin
                flush_v = 1'b0;
            end
        endcase
    end

    // Token outputs.
    always_comb begin
        p     = '{kind: flush_kind, line: r_sline, column: r_scol, offset: r_soff,
                  length: flush_len, last: 1'b0};
        q     = '{kind: op_kind(c), line: r_line, column: r_col, offset: r_off,
                  length: OFF_ONE, last: 1'b1};
        p_v   = 1'b0;
        q_v   = 1'b0;
        if (eot) begin
            p_v      = flush_v;
            q.kind   = KIND_EOT;
            q.length = OFF_ZERO;
            q_v      = 1'b1;
        end else if (busy && !cont) begin
            if (pair_v) begin
                p_v      = 1'b1;
                p.kind   = pair_kind;
                p.length = OFF_TWO;
            end else begin
                p_v = flush_v;
                q_v = !(c_space || c_letter || c_digit || c_pend);
            end
        end
    end

    always_comb begin
        o_push.n    = i_fire ? (2'(p_v) + 2'(q_v)) : 2'd0;
        o_push.tok0 = p_v ? p : q;
        o_push.tok0.last = !(p_v && q_v);
        o_push.tok1 = q;
    end

    // Next state.
    always_comb begin
        n_mode  = r_mode;
        n_wlen  = r_wlen;
        n_line  = r_line;
        n_col   = r_col;
        n_off   = r_off;
        n_sline = r_sline;
        n_scol  = r_scol;
        n_soff  = r_soff;
        buf_we  = 1'b0;
        buf_idx = '0;
        if (eot) begin
            n_mode  = MODE_IDLE;
            n_wlen  = OFF_ZERO;
            n_line  = POS_ONE;
            n_col   = POS_ONE;
            n_off   = OFF_ZERO;
            n_sline = POS_ONE;
            n_scol  = POS_ONE;
            n_soff  = OFF_ZERO;
        end else if (busy) begin
            n_off = sat_off(r_off);
            if (c == CH_NL) begin
                n_line = sat_pos(r_line);
                n_col  = POS_ONE;
            end else begin
                n_col = sat_pos(r_col);
            end
            if (cont) begin
                n_wlen = sat_off(r_wlen);
                if (r_mode == MODE_WORD && r_wlen < OFFSET_BITS'(KW_MAX_LEN)) begin
                    buf_we  = 1'b1;
                    buf_idx = r_wlen[KW_IDX_W-1:0];
                end
            end else begin
                n_mode = MODE_IDLE;
                if (!pair_v) begin
                    if (c_letter || c_digit || c_pend) begin
                        n_sline = r_line;
                        n_scol  = r_col;
                        n_soff  = r_off;
                    end
                    if (c_letter || c_digit) begin
                        buf_we  = 1'b1;
                        n_wlen  = OFF_ONE;
                        n_mode  = c_letter ? MODE_WORD : MODE_NUM;
                    end else if (c == CH_LT) begin
                        n_mode = MODE_LT;
                    end else if (c == CH_GT) begin
                        n_mode = MODE_GT;
                    end else if (c == CH_COLON) begin
                        n_mode = MODE_COLON;
                    end else if (!c_space && op_kind(c) == KIND_ERROR) begin
                        n_mode = MODE_ERR;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_IDLE;
            r_wlen  <= OFF_ZERO;
            r_line  <= POS_ONE;
            r_col   <= POS_ONE;
            r_off   <= OFF_ZERO;
            r_sline <= POS_ONE;
            r_scol  <= POS_ONE;
            r_soff  <= OFF_ZERO;
        end else if (i_fire) begin
            r_mode  <= n_mode;
            r_wlen  <= n_wlen;
            r_line  <= n_line;
            r_col   <= n_col;
            r_off   <= n_off;
            r_sline <= n_sline;
            r_scol  <= n_scol;
            r_soff  <= n_soff;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire && buf_we) begin
            r_buf[buf_idx] <= c;
        end
    end

    `KWT_ASSERT_NEXT(a_eot_resets, i_fire && eot, r_mode == MODE_IDLE && r_off == OFF_ZERO)
    `KWT_ASSERT_NEXT(a_err_sticky, r_mode == MODE_ERR && !(i_fire && eot), r_mode == MODE_ERR)
    `KWT_ASSERT_IMPL(a_two_last, o_push.n == 2'd2, !o_push.tok0.last && o_push.tok1.last)

endmodule

// ===== rtl/kwt_outq.sv =====
// Token queue: four register slots that take up to two tokens a cycle
// and hand one a cycle to a ready output channel. Depends on kwt_pkg.
`timescale 1ns / 1ps
`include "keyword_token_lexer_core_assert.svh"

module kwt_outq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  kwt_pkg::t_push  i_push,
    input  logic            i_pop,
    output logic            o_valid,
    output logic            o_room,
    output kwt_pkg::t_token o_head
);
    import kwt_pkg::*;

    t_token r_slot [OQ_DEPTH];
    logic [OQ_PTR_W-1:0] r_wptr, r_rptr;
    logic [OQ_CNT_W-1:0] r_count;
    logic pop;

    assign o_valid = (r_count != '0);
    assign o_room  = (r_count <= OQ_CNT_W'(OQ_DEPTH - 2));
    assign o_head  = r_slot[r_rptr];
    assign pop     = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= r_wptr + OQ_PTR_W'(i_push.n);
            r_rptr  <= r_rptr + OQ_PTR_W'(pop);
            r_count <= r_count + OQ_CNT_W'(i_push.n) - OQ_CNT_W'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.n != 2'd0) begin
            r_slot[r_wptr] <= i_push.tok0;
        end
        if (i_push.n == 2'd2) begin
            r_slot[r_wptr + OQ_PTR_W'(1)] <= i_push.tok1;
        end
    end

    `KWT_ASSERT_IMPL(a_no_overflow, 1'b1, r_count <= OQ_CNT_W'(OQ_DEPTH))
    `KWT_ASSERT_NEXT(a_push_two, i_push.n == 2'd2 && !pop, r_count == $past(r_count) + 3'd2)

endmodule

// ===== rtl/keyword_token_lexer_core.sv =====
// Top level of the keyword token lexer: input register, scan stage and
// token queue. Depends on kwt_pkg, kwt_ifs, kwt_scan and kwt_outq.
//
// i_text carries source bytes, one per item; an item with end_of_text set
// carries no byte, flushes any pending token and ends with the end token.
// o_token carries tokens; last_of_run marks the final token of an input item.
// An item is taken into an input register, scanned from there by the scan
// stage and its tokens are written to a four-slot queue, whose head is the
// token offered on o_token. One item is accepted every cycle while items
// give at most one token and the receiver takes every token; an item that
// gives two tokens hands them out in turn through the single queue port.
// Reset returns the lexer to line 1, column 1, offset 0 and empties the
// queue. When the receiver stalls, the queue fills, the scan stage holds
// its item and i_text.ready drops; no token is lost or repeated.
`timescale 1ns / 1ps

module keyword_token_lexer_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    kwt_text_if.sink    i_text,
    kwt_token_if.source o_token
);
    import kwt_pkg::*;

    logic   r_in_valid;
    t_item  r_in;
    logic   fire, accept, room;
    t_push  push;
    t_token head;

    assign fire         = r_in_valid && room;
    assign i_text.ready = !r_in_valid || fire;
    assign accept       = i_text.valid && i_text.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in.text_byte   <= i_text.text_byte;
            r_in.end_of_text <= i_text.end_of_text;
        end
    end

    kwt_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_item  (r_in),
        .o_push  (push)
    );

    kwt_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (o_token.ready),
        .o_valid (o_token.valid),
        .o_room  (room),
        .o_head  (head)
    );

    assign o_token.token_kind   = head.kind;
    assign o_token.start_line   = head.line;
    assign o_token.start_column = head.column;
    assign o_token.start_offset = head.offset;
    assign o_token.token_length = head.length;
    assign o_token.last_of_run  = head.last;

endmodule

// ===== bench/keyword_token_lexer_core_checker.sv =====
// Token checker for the keyword token lexer: predicts the tokens of every accepted
// text item and compares them with the tokens the lexer hands out.
// Depends on kwt_pkg and kwt_ifs.
`timescale 1ns / 1ps

module keyword_token_lexer_core_checker (
    input  logic  i_clk,
    input  logic  i_rst_n,
    kwt_text_if   i_text,
    kwt_token_if  i_token,
    output int    o_fail_count,
    output int    o_tokens_due
);
    import kwt_pkg::*;

    string reserved_words [KW_COUNT] = '{
        "program", "var", "begin", "end", "int", "if",
        "then", "else", "while", "do", "read", "write"
    };

    t_mode  scan;
    t_char  word_chars [KW_MAX_LEN];
    t_off   run_len;
    t_pos   line_now;
    t_pos   col_now;
    t_off   off_now;
    t_pos   tok_line;
    t_pos   tok_col;
    t_off   tok_off;
    t_token tokens_due [$];
    t_token step_out [2];
    int     step_n;
    int     fail_total;

    function automatic t_pos pos_inc(input t_pos v);
        if (v == '1) begin
            return v;
        end
        return v + 1'b1;
    endfunction

    function automatic t_off off_inc(input t_off v);
        if (v == '1) begin
            return v;
        end
        return v + 1'b1;
    endfunction

    function automatic logic blank_char(input t_char c);
        return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic letter_char(input t_char c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function automatic logic digit_char(input t_char c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic t_kind single_kind(input t_char c);
        case (c)
            "=":     return KIND_EQ;
            "+":     return KIND_PLUS;
            "-":     return KIND_MINUS;
            "*":     return KIND_MUL;
            "/":     return KIND_DIV;
            "(":     return KIND_LPAR;
            ")":     return KIND_RPAR;
            ";":     return KIND_SEMI;
            "[":     return KIND_LBRK;
            "]":     return KIND_RBRK;
            default: return KIND_ERROR;
        endcase
    endfunction

    function automatic string token_text(input t_token t);
        return $sformatf("kind %0d line %0d col %0d off %0d len %0d last %0b",
                         t.kind, t.line, t.column, t.offset, t.length, t.last);
    endfunction

    // A word longer than the keyword buffer never matches, since no keyword is that long.
    function automatic t_kind classify_word();
        t_kind k;
        logic  same;
        k = KIND_IDENT;
        for (int i = 0; i < KW_COUNT; i++) begin
            if (run_len == t_off'(reserved_words[i].len())) begin
                same = 1'b1;
                for (int j = 0; j < reserved_words[i].len(); j++) begin
                    same = same && (word_chars[j] == t_char'(reserved_words[i][j]));
                end
                if (same) begin
                    k = t_kind'(KIND_KW0 + i);
                end
            end
        end
        return k;
    endfunction

    task automatic clear_state();
        scan = MODE_IDLE;
        foreach (word_chars[i]) begin
            word_chars[i] = 8'd0;
        end
        run_len  = OFF_ZERO;
        line_now = POS_ONE;
        col_now  = POS_ONE;
        off_now  = OFF_ZERO;
        tok_line = POS_ONE;
        tok_col  = POS_ONE;
        tok_off  = OFF_ZERO;
    endtask

    task automatic add_token(input t_kind k, input t_pos ln, input t_pos cl, input t_off of,
                             input t_off len);
        t_token t;
        t.kind   = k;
        t.line   = ln;
        t.column = cl;
        t.offset = of;
        t.length = len;
        t.last   = 1'b0;
        step_out[step_n] = t;
        step_n++;
    endtask

    task automatic step_over(input t_char c);
        off_now = off_inc(off_now);
        if (c == CH_NL) begin
            line_now = pos_inc(line_now);
            col_now  = POS_ONE;
        end else begin
            col_now = pos_inc(col_now);
        end
    endtask

    task automatic mark_here();
        tok_line = line_now;
        tok_col  = col_now;
        tok_off  = off_now;
    endtask

    task automatic flush_pending();
        case (scan)
            MODE_WORD:  add_token(classify_word(), tok_line, tok_col, tok_off, run_len);
            MODE_NUM:   add_token(KIND_NUMBER, tok_line, tok_col, tok_off, run_len);
            MODE_LT:    add_token(KIND_LSS, tok_line, tok_col, tok_off, OFF_ONE);
            MODE_GT:    add_token(KIND_GTR, tok_line, tok_col, tok_off, OFF_ONE);
            MODE_COLON: add_token(KIND_COLON, tok_line, tok_col, tok_off, OFF_ONE);
            default: ;
        endcase
        scan = MODE_IDLE;
    endtask

    task automatic close_pair(input t_char c, input t_kind k);
        add_token(k, tok_line, tok_col, tok_off, OFF_TWO);
        scan = MODE_IDLE;
        step_over(c);
    endtask

    task automatic from_idle(input t_char c);
        t_kind k;
        if (blank_char(c)) begin
            step_over(c);
        end else if (letter_char(c) || digit_char(c)) begin
            mark_here();
            word_chars[0] = c;
            run_len = OFF_ONE;
            scan = letter_char(c) ? MODE_WORD : MODE_NUM;
            step_over(c);
        end else if (c == CH_LT || c == CH_GT || c == CH_COLON) begin
            mark_here();
            scan = (c == CH_LT) ? MODE_LT : ((c == CH_GT) ? MODE_GT : MODE_COLON);
            step_over(c);
        end else begin
            k = single_kind(c);
            add_token(k, line_now, col_now, off_now, OFF_ONE);
            if (k == KIND_ERROR) begin
                scan = MODE_ERR;
            end
            step_over(c);
        end
    endtask

    task automatic lex_item(input t_char c, input logic eot);
        step_n = 0;
        if (eot) begin
            flush_pending();
            add_token(KIND_EOT, line_now, col_now, off_now, OFF_ZERO);
            clear_state();
        end else begin
            case (scan)
                MODE_ERR: ;
                MODE_WORD: begin
                    if (letter_char(c) || digit_char(c)) begin
                        if (run_len < KW_MAX_LEN) begin
                            word_chars[run_len] = c;
                        end
                        run_len = off_inc(run_len);
                        step_over(c);
                    end else begin
                        flush_pending();
                        from_idle(c);
                    end
                end
                MODE_NUM: begin
                    if (digit_char(c)) begin
                        run_len = off_inc(run_len);
                        step_over(c);
                    end else begin
                        flush_pending();
                        from_idle(c);
                    end
                end
                MODE_LT: begin
                    if (c == CH_EQ) begin
                        close_pair(c, KIND_LEQ);
                    end else if (c == CH_GT) begin
                        close_pair(c, KIND_NEQ);
                    end else begin
                        flush_pending();
                        from_idle(c);
                    end
                end
                MODE_GT: begin
                    if (c == CH_EQ) begin
                        close_pair(c, KIND_GEQ);
                    end else begin
                        flush_pending();
                        from_idle(c);
                    end
                end
                MODE_COLON: begin
                    if (c == CH_EQ) begin
                        close_pair(c, KIND_ASSIGN);
                    end else begin
                        flush_pending();
                        from_idle(c);
                    end
                end
                default: begin
                    scan = MODE_IDLE;
                    from_idle(c);
                end
            endcase
        end
        if (step_n > 0) begin
            step_out[step_n - 1].last = 1'b1;
        end
        for (int i = 0; i < step_n; i++) begin
            tokens_due = {tokens_due, step_out[i]};
        end
    endtask

    task automatic take_token();
        t_token seen;
        t_token want;
        seen.kind   = i_token.token_kind;
        seen.line   = i_token.start_line;
        seen.column = i_token.start_column;
        seen.offset = i_token.start_offset;
        seen.length = i_token.token_length;
        seen.last   = i_token.last_of_run;
        if (tokens_due.size() == 0) begin
            if (fail_total < 10) begin
                $display("unexpected token at %0t: %s", $realtime, token_text(seen));
            end
            fail_total++;
        end else begin
            want = tokens_due.pop_front();
            if (seen.kind !== want.kind || seen.line !== want.line ||
                seen.column !== want.column || seen.offset !== want.offset ||
                seen.length !== want.length || seen.last !== want.last) begin
                if (fail_total < 10) begin
                    $display("token mismatch at %0t: expected %s, got %s", $realtime,
                             token_text(want), token_text(seen));
                end
                fail_total++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_state();
        end else begin
            if (i_token.valid && i_token.ready) begin
                take_token();
            end
            if (i_text.valid && i_text.ready) begin
                lex_item(i_text.text_byte, i_text.end_of_text);
            end
        end
        o_fail_count = fail_total;
        o_tokens_due = tokens_due.size();
    end

endmodule

// ===== bench/keyword_token_lexer_core_test.sv =====
// Testbench top for the keyword token lexer: drives source text with random gaps,
// stalls the token side and reports the verdict of the token checker.
// Depends on kwt_pkg, kwt_ifs, keyword_token_lexer_core and its checker.
`timescale 1ns / 1ps

module keyword_token_lexer_core_test;
    import kwt_pkg::*;

    localparam int CYCLE_LIMIT     = 100_000;
    localparam int RANDOM_ITEMS    = 1000;
    localparam int QUIET_ITEMS     = 250;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int DRAIN_CYCLES    = 20;

    logic clk = 1'b0;
    logic rst_n;
    logic idle_on;
    logic hold_off_req;
    logic hold_off_done;
    int   fail_count;
    int   tokens_due;
    int   cycle_count = 0;
    int   items_sent;
    int   stray;

    string kw_list [KW_COUNT] = '{
        "program", "var", "begin", "end", "int", "if",
        "then", "else", "while", "do", "read", "write"
    };
    string op_list [17] = '{
        ":=", "+", "-", "*", "/", "=", "<", ">", "<=", ">=", "<>",
        ";", ":", "(", ")", "[", "]"
    };

    kwt_text_if  text_ch ();
    kwt_token_if token_ch ();

    keyword_token_lexer_core DUT (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_text  (text_ch),
        .o_token (token_ch)
    );

    keyword_token_lexer_core_checker token_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_text       (text_ch),
        .i_token      (token_ch),
        .o_fail_count (fail_count),
        .o_tokens_due (tokens_due)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[keyword_token_lexer_core] ERROR");
            $finish;
        end
    end

    function automatic t_char pick_letter();
        int r;
        r = $urandom_range(51);
        return (r < 26) ? t_char'(CH_UPPER_A + r) : t_char'(CH_LOWER_A + r - 26);
    endfunction

    function automatic t_char pick_alnum();
        if ($urandom_range(3) == 0) begin
            return t_char'(CH_0 + $urandom_range(9));
        end
        return pick_letter();
    endfunction

    function automatic t_char pick_blank();
        int r;
        r = $urandom_range(5);
        if (r < 2) begin
            return CH_SPACE;
        end else if (r == 2) begin
            return CH_NL;
        end
        return t_char'(CH_TAB + $urandom_range(4));
    endfunction

    // Called at a falling edge; returns at the falling edge after the item is taken.
    task automatic send_item(input t_char b, input logic eot);
        while (idle_on && $urandom_range(99) < 7) begin
            text_ch.valid <= 1'b0;
            @(negedge clk);
        end
        text_ch.valid       <= 1'b1;
        text_ch.text_byte   <= b;
        text_ch.end_of_text <= eot;
        @(posedge clk);
        while (!text_ch.ready) begin
            @(posedge clk);
        end
        items_sent++;
        @(negedge clk);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            send_item(t_char'(s[i]), 1'b0);
        end
    endtask

    task automatic random_text();
        int    n_tokens;
        int    pick;
        int    len;
        int    shape;
        int    flip_at;
        t_char c;
        string w;
        n_tokens = $urandom_range(12, 1);
        for (int t = 0; t < n_tokens; t++) begin
            pick = $urandom_range(99);
            if (pick < 20) begin
                w = kw_list[$urandom_range(KW_COUNT - 1)];
                len = w.len();
                shape = $urandom_range(9);
                flip_at = $urandom_range(len - 1);
                if (shape == 9) begin
                    len--;
                end
                for (int i = 0; i < len; i++) begin
                    c = t_char'(w[i]);
                    if (shape == 7 && i == flip_at) begin
                        c = c ^ 8'h20;
                    end
                    send_item(c, 1'b0);
                end
                if (shape == 8) begin
                    send_item(pick_alnum(), 1'b0);
                end
            end else if (pick < 40) begin
                send_item(pick_letter(), 1'b0);
                len = $urandom_range(9);
                repeat (len) send_item(pick_alnum(), 1'b0);
            end else if (pick < 55) begin
                len = $urandom_range(6, 1);
                repeat (len) send_item(t_char'(CH_0 + $urandom_range(9)), 1'b0);
            end else if (pick < 85) begin
                send_text(op_list[$urandom_range(16)]);
            end else if (pick < 88) begin
                send_item(t_char'($urandom_range(255)), 1'b0);
                len = $urandom_range(3);
                stray += len;
                repeat (len) send_item(t_char'($urandom_range(255)), 1'b0);
                break;
            end else begin
                send_item(pick_blank(), 1'b0);
            end
            if ($urandom_range(99) < 60) begin
                send_item(pick_blank(), 1'b0);
            end
        end
        send_item(t_char'($urandom_range(255)), 1'b1);
    endtask

    initial begin
        token_ch.ready = 1'b0;
        hold_off_done  = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_off_req && !hold_off_done) begin
                token_ch.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
                hold_off_done = 1'b1;
            end else begin
                token_ch.ready <= !(idle_on && $urandom_range(99) < 7);
            end
        end
    end

    initial begin
        int start_count;
        rst_n               = 1'b0;
        idle_on             = 1'b1;
        hold_off_req        = 1'b0;
        items_sent          = 0;
        stray               = 0;
        text_ch.valid       = 1'b0;
        text_ch.text_byte   = 8'd0;
        text_ch.end_of_text = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_text("x:=1<+2>=3<=4<>5>");
        send_item(8'h00, 1'b1);
        send_item(8'h00, 1'b0);
        send_item(8'hFF, 1'b0);
        send_item(8'hFF, 1'b1);
        send_item(8'h00, 1'b1);
        send_text(":");
        send_item(8'h00, 1'b1);

        // A stretch of text with no idle cycles on either side.
        idle_on     = 1'b0;
        start_count = items_sent;
        while (items_sent - start_count < QUIET_ITEMS) begin
            random_text();
        end
        idle_on = 1'b1;

        hold_off_req = 1'b1;
        while (items_sent - start_count - stray < RANDOM_ITEMS) begin
            random_text();
        end

        text_ch.valid <= 1'b0;
        while (tokens_due != 0) begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0 && tokens_due == 0) begin
            $display("[keyword_token_lexer_core] OK");
        end else begin
            $display("[keyword_token_lexer_core] ERROR");
        end
        $finish;
    end

endmodule
